// ----- hdl/qlb_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and defaults for the multicore queue load balancer
// no dependencies; imported by every module of the block
package qlb_pkg;

  localparam int CORE_COUNT_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  // field widths fixed by the interface
  localparam int OP_W   = 2;
  localparam int CORE_W = 2;
  localparam int ID_W   = 8;
  localparam int LOAD_W = 3;
  localparam int TIME_W = 16;
  localparam int KIND_W = 4;
  localparam int Q_W    = 8;
  localparam int PCT_W  = 7;
  localparam int ACT_W  = 3;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 8;

  // configuration reset values
  localparam logic [ACT_W-1:0] ACTIVE_RST  = 3'd2;
  localparam logic [Q_W-1:0]   QUANTUM_RST = 8'd15;
  localparam logic [PCT_W-1:0] PCT_RST     = 7'd20;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PCT     = 2'd2;

  // percent scale of the threshold compare
  localparam int PCT_SCALE = 100;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE  = 2'd0,
    OP_RUN     = 2'd1,
    OP_BALANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_ASSIGNED    = 4'd0,
    K_REJECTED    = 4'd1,
    K_REQUEUED    = 4'd2,
    K_COMPLETED   = 4'd3,
    K_IDLE        = 4'd4,
    K_MOVED       = 4'd5,
    K_MOVED_DROP  = 4'd6,
    K_NO_MOVE     = 4'd7,
    K_TARGET_FULL = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARRIVE,
    S_RUN_CHK,
    S_RUN_UPD,
    S_SCAN,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_MV_RD,
    S_MV_DST,
    S_MV_POP
  } state_t;

  // one task store entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LOAD_W-1:0] load;
    logic [TIME_W-1:0] remaining;
  } task_t;

endpackage

// ----- hdl/multicore_queue_load_balancer.sv -----
`timescale 1ns / 1ps
// top level: command sequencer, configuration registers and result register
// depends on qlb_pkg, qlb_task_mem, qlb_core_tbl
//
//  channel  handshake              payload
//  in       start / busy           in_op in_core in_task_id in_load in_run_time
//  out      out_valid (strobe)     out_kind out_core_out out_other_core out_task_out
//                                  out_slice out_remaining
//  cfg      cfg_valid / cfg_ready  cfg_index cfg_data
//
// transaction steps: arrival checks the queue and pushes or rejects; run slice does one task store
// read, then read-modify-write, and stops at the check on an empty queue; balance covers n
// active cores through the one-core-a-cycle load scan, the registered threshold multiplies
// and the move steps. busy falls in the cycle the result shows.
// reset clears the queues and loads at once; the task store needs no clearing.
// results are a one-cycle strobe and the receiver cannot stall them.
module multicore_queue_load_balancer import qlb_pkg::*; #(
  parameter int CORE_COUNT  = CORE_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_op,
  input  logic [CORE_W-1:0] in_core,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [LOAD_W-1:0] in_load,
  input  logic [TIME_W-1:0] in_run_time,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [CORE_W-1:0] out_core_out,
  output logic [CORE_W-1:0] out_other_core,
  output logic [ID_W-1:0]   out_task_out,
  output logic [Q_W-1:0]    out_slice,
  output logic [TIME_W-1:0] out_remaining,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data
);

  localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int NW = $clog2(CORE_COUNT + 1);
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int QW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = $clog2(7 * QUEUE_DEPTH + 1);
  localparam int TW = $clog2(CORE_COUNT * 7 * QUEUE_DEPTH + 1);
  localparam int AW = (CORE_COUNT * QUEUE_DEPTH > 1) ? $clog2(CORE_COUNT * QUEUE_DEPTH) : 1;
  localparam int DW = NW + LW;
  localparam int PW = NW + TW + PCT_W;

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  active_r;
  logic [Q_W-1:0]    quantum_r;
  logic [PCT_W-1:0]  pct_r;
  logic [CW-1:0]     next_core_r, next_core_nxt;
  logic [CW-1:0]     sel_r, sel_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     src_r, src_nxt, dst_r, dst_nxt;
  logic [LW-1:0]     maxl_r, maxl_nxt, minl_r, minl_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [DW-1:0]     nd_r, nd_nxt;
  logic [PW-1:0]     pa_r, pa_nxt, pb_r, pb_nxt;
  task_t             tsk_r, tsk_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [CORE_W-1:0] out_core_r, out_core_nxt, out_other_r, out_other_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [Q_W-1:0]    out_slice_r, out_slice_nxt;
  logic [TIME_W-1:0] out_rem_r, out_rem_nxt;

  // core table and task store ports
  logic          tbl_we;
  logic [HW-1:0] tbl_head_wr, head_q;
  logic [QW-1:0] tbl_cnt_wr, cnt_q;
  logic [LW-1:0] tbl_load_wr, load_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  task_t         mem_wdata, mem_rdata;

  // derived values of the selected core
  logic [NW-1:0]   n_act;
  logic [CW-1:0]   arr_core;
  logic [HW-1:0]   slot, head_inc;
  logic [QW:0]     slot_sum;
  logic [AW-1:0]   base_addr;
  logic            q_full;
  logic [Q_W-1:0]  q_eff, slice_v;
  logic [TIME_W-1:0] rem_v;

  qlb_core_tbl #(
    .CORE_COUNT(CORE_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH),
    .CW(CW), .HW(HW), .QW(QW), .LW(LW)
  ) u_core_tbl (
    .clk(clk), .rst_n(rst_n), .sel(sel_r), .we(tbl_we),
    .head_wr(tbl_head_wr), .cnt_wr(tbl_cnt_wr), .load_wr(tbl_load_wr),
    .head_rd(head_q), .cnt_rd(cnt_q), .load_rd(load_q)
  );

  qlb_task_mem #(.DEPTH(CORE_COUNT * QUEUE_DEPTH), .AW(AW)) u_task_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // active core count, clamped
  always_comb begin
    if (active_r == '0) begin
      n_act = NW'(1);
    end else if (5'(active_r) > 5'(CORE_COUNT)) begin
      n_act = NW'(CORE_COUNT);
    end else begin
      n_act = NW'(active_r);
    end
  end

  assign arr_core = (NW'(next_core_r) < n_act) ? next_core_r : '0;

  // queue geometry of the selected core
  assign slot_sum  = (QW+1)'(head_q) + (QW+1)'(cnt_q);
  assign slot      = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc  = ((HW+1)'(head_q) + 1'b1 == (HW+1)'(QUEUE_DEPTH)) ?
                     '0 : head_q + 1'b1;
  assign base_addr = AW'(sel_r) * AW'(QUEUE_DEPTH);
  assign q_full    = (cnt_q == QW'(QUEUE_DEPTH));

  // slice of the task just read
  assign q_eff   = (quantum_r == '0) ? Q_W'(1) : quantum_r;
  assign slice_v = (mem_rdata.remaining < TIME_W'(q_eff)) ?
                   mem_rdata.remaining[Q_W-1:0] : q_eff;
  assign rem_v   = mem_rdata.remaining - TIME_W'(slice_v);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    next_core_nxt = next_core_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    maxl_nxt      = maxl_r;
    minl_nxt      = minl_r;
    total_nxt     = total_r;
    nd_nxt        = nd_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    tsk_nxt       = tsk_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_core_nxt  = out_core_r;
    out_other_nxt = out_other_r;
    out_id_nxt    = out_id_r;
    out_slice_nxt = out_slice_r;
    out_rem_nxt   = out_rem_r;
    tbl_we        = 1'b0;
    tbl_head_wr   = head_q;
    tbl_cnt_wr    = cnt_q;
    tbl_load_wr   = load_q;
    mem_we        = 1'b0;
    mem_waddr     = base_addr + AW'(slot);
    mem_wdata     = tsk_r;
    mem_re        = 1'b0;
    mem_raddr     = base_addr + AW'(head_q);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          tsk_nxt = '{id: in_task_id, load: in_load, remaining: in_run_time};
          case (op_t'(in_op))
            OP_ARRIVE: begin
              sel_nxt       = arr_core;
              next_core_nxt = (NW'(arr_core) + 1'b1 == n_act) ? '0 : arr_core + 1'b1;
              state_nxt     = S_ARRIVE;
            end
            OP_RUN: begin
              if (5'(in_core) >= 5'(CORE_COUNT)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = K_IDLE;
                out_core_nxt  = in_core;
                out_other_nxt = '0;
                out_id_nxt    = '0;
                out_slice_nxt = '0;
                out_rem_nxt   = '0;
              end else begin
                sel_nxt   = CW'(in_core);
                state_nxt = S_RUN_CHK;
              end
            end
            OP_BALANCE: begin
              sel_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      // arrival: push at the tail or reject
      S_ARRIVE: begin
        out_valid_nxt = 1'b1;
        out_core_nxt  = CORE_W'(sel_r);
        out_other_nxt = '0;
        out_id_nxt    = tsk_r.id;
        out_slice_nxt = '0;
        out_rem_nxt   = tsk_r.remaining;
        if (q_full) begin
          out_kind_nxt = K_REJECTED;
        end else begin
          out_kind_nxt = K_ASSIGNED;
          mem_we       = 1'b1;
          tbl_we       = 1'b1;
          tbl_cnt_wr   = cnt_q + 1'b1;
          tbl_load_wr  = load_q + LW'(tsk_r.load);
        end
        state_nxt = S_IDLE;
      end

      // run: read the head entry
      S_RUN_CHK: begin
        if (cnt_q == '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_IDLE;
          out_core_nxt  = CORE_W'(sel_r);
          out_other_nxt = '0;
          out_id_nxt    = '0;
          out_slice_nxt = '0;
          out_rem_nxt   = '0;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_RUN_UPD;
        end
      end

      // run: pop, then requeue or complete
      S_RUN_UPD: begin
        out_valid_nxt = 1'b1;
        out_core_nxt  = CORE_W'(sel_r);
        out_other_nxt = '0;
        out_id_nxt    = mem_rdata.id;
        out_slice_nxt = slice_v;
        out_rem_nxt   = rem_v;
        tbl_we        = 1'b1;
        tbl_head_wr   = head_inc;
        if (rem_v != '0) begin
          out_kind_nxt = K_REQUEUED;
          mem_we       = 1'b1;
          mem_wdata    = '{id: mem_rdata.id, load: mem_rdata.load, remaining: rem_v};
        end else begin
          out_kind_nxt = K_COMPLETED;
          tbl_cnt_wr   = cnt_q - 1'b1;
          tbl_load_wr  = load_q - LW'(mem_rdata.load);
        end
        state_nxt = S_IDLE;
      end

      // balance: one core load a cycle
      S_SCAN: begin
        if (idx_r == '0) begin
          maxl_nxt  = load_q;
          minl_nxt  = load_q;
          total_nxt = TW'(load_q);
          src_nxt   = '0;
          dst_nxt   = '0;
        end else begin
          total_nxt = total_r + TW'(load_q);
          if (load_q > maxl_r) begin
            maxl_nxt = load_q;
            src_nxt  = idx_r;
          end
          if (load_q < minl_r) begin
            minl_nxt = load_q;
            dst_nxt  = idx_r;
          end
        end
        if (NW'(idx_r) + 1'b1 == n_act) begin
          state_nxt = S_MUL1;
        end else begin
          idx_nxt = idx_r + 1'b1;
          sel_nxt = idx_r + 1'b1;
        end
      end

      S_MUL1: begin
        nd_nxt    = DW'(n_act) * DW'(maxl_r - minl_r);
        pb_nxt    = PW'(pct_r) * PW'(total_r);
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        pa_nxt    = PW'(nd_r) * PW'(PCT_SCALE);
        sel_nxt   = src_r;
        state_nxt = S_CMP;
      end

      // threshold test, read the busiest head
      S_CMP: begin
        if (pa_r <= pb_r || cnt_q == '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_NO_MOVE;
          out_core_nxt  = '0;
          out_other_nxt = '0;
          out_id_nxt    = '0;
          out_slice_nxt = '0;
          out_rem_nxt   = '0;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_MV_RD;
        end
      end

      S_MV_RD: begin
        tsk_nxt = mem_rdata;
        if (mem_rdata.remaining == '0) begin
          tbl_we        = 1'b1;
          tbl_head_wr   = head_inc;
          tbl_cnt_wr    = cnt_q - 1'b1;
          tbl_load_wr   = load_q - LW'(mem_rdata.load);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_MOVED_DROP;
          out_core_nxt  = CORE_W'(src_r);
          out_other_nxt = CORE_W'(dst_r);
          out_id_nxt    = mem_rdata.id;
          out_slice_nxt = '0;
          out_rem_nxt   = '0;
          state_nxt     = S_IDLE;
        end else begin
          sel_nxt   = dst_r;
          state_nxt = S_MV_DST;
        end
      end

      // push onto the idlest core
      S_MV_DST: begin
        if (q_full) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_TARGET_FULL;
          out_core_nxt  = CORE_W'(src_r);
          out_other_nxt = CORE_W'(dst_r);
          out_id_nxt    = tsk_r.id;
          out_slice_nxt = '0;
          out_rem_nxt   = tsk_r.remaining;
          state_nxt     = S_IDLE;
        end else begin
          mem_we      = 1'b1;
          tbl_we      = 1'b1;
          tbl_cnt_wr  = cnt_q + 1'b1;
          tbl_load_wr = load_q + LW'(tsk_r.load);
          sel_nxt     = src_r;
          state_nxt   = S_MV_POP;
        end
      end

      // pop from the busiest core
      S_MV_POP: begin
        tbl_we        = 1'b1;
        tbl_head_wr   = head_inc;
        tbl_cnt_wr    = cnt_q - 1'b1;
        tbl_load_wr   = load_q - LW'(tsk_r.load);
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_MOVED;
        out_core_nxt  = CORE_W'(src_r);
        out_other_nxt = CORE_W'(dst_r);
        out_id_nxt    = tsk_r.id;
        out_slice_nxt = '0;
        out_rem_nxt   = tsk_r.remaining;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_core_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_core_r <= next_core_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    sel_r       <= sel_nxt;
    idx_r       <= idx_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    maxl_r      <= maxl_nxt;
    minl_r      <= minl_nxt;
    total_r     <= total_nxt;
    nd_r        <= nd_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    tsk_r       <= tsk_nxt;
    out_kind_r  <= out_kind_nxt;
    out_core_r  <= out_core_nxt;
    out_other_r <= out_other_nxt;
    out_id_r    <= out_id_nxt;
    out_slice_r <= out_slice_nxt;
    out_rem_r   <= out_rem_nxt;
  end

  // configuration transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RST;
      quantum_r <= QUANTUM_RST;
      pct_r     <= PCT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE:  active_r  <= cfg_data[ACT_W-1:0];
        CFG_QUANTUM: quantum_r <= cfg_data[Q_W-1:0];
        CFG_PCT:     pct_r     <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready      = 1'b1;
  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_core_out   = out_core_r;
  assign out_other_core = out_other_r;
  assign out_task_out   = out_id_r;
  assign out_slice      = out_slice_r;
  assign out_remaining  = out_rem_r;

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a command is still in work");

  a_move_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MV_DST || state_r == S_MV_POP) |-> (src_r != dst_r))
    else $error("move between the same core");

  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("task store read and written in one cycle");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN_UPD || state_r == S_MV_RD) |-> $past(mem_re))
    else $error("task store data used without a read");

endmodule

// ----- hdl/qlb_task_mem.sv -----
`timescale 1ns / 1ps
// task store: one write port, one read port, registered read data
// depends on qlb_pkg for the task entry type
module qlb_task_mem import qlb_pkg::*; #(
  parameter int DEPTH = CORE_COUNT_DEF * QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(CORE_COUNT_DEF * QUEUE_DEPTH_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  task_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output task_t         rdata
);

  task_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/qlb_core_tbl.sv -----
`timescale 1ns / 1ps
// per-core queue head, fill count and load sum, accessed at one selected core
// depends on qlb_pkg
module qlb_core_tbl import qlb_pkg::*; #(
  parameter int CORE_COUNT  = CORE_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1,
  parameter int HW = $clog2(QUEUE_DEPTH),
  parameter int QW = $clog2(QUEUE_DEPTH + 1),
  parameter int LW = $clog2(7 * QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] sel,
  input  logic          we,
  input  logic [HW-1:0] head_wr,
  input  logic [QW-1:0] cnt_wr,
  input  logic [LW-1:0] load_wr,
  output logic [HW-1:0] head_rd,
  output logic [QW-1:0] cnt_rd,
  output logic [LW-1:0] load_rd
);

  logic [HW-1:0] head_r [CORE_COUNT];
  logic [QW-1:0] cnt_r  [CORE_COUNT];
  logic [LW-1:0] load_r [CORE_COUNT];

  // update of the selected core
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORE_COUNT; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        load_r[i] <= '0;
      end
    end else if (we) begin
      head_r[sel] <= head_wr;
      cnt_r[sel]  <= cnt_wr;
      load_r[sel] <= load_wr;
    end
  end

  // selected core view
  assign head_rd = head_r[sel];
  assign cnt_rd  = cnt_r[sel];
  assign load_rd = load_r[sel];

  a_cnt_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (QW+1)'(cnt_wr) <= (QW+1)'(QUEUE_DEPTH))
    else $error("queue count written beyond depth");

  a_load_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_rd == '0) |-> (load_rd == '0))
    else $error("empty queue holds a nonzero load");

endmodule
